### src/timed_event_queue_defines.svh
// Assertion macros for the timed event queue.
// Used by the top level only; needs no other file.
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/teq_pkg.sv
// Package for the timed event queue: sizes, codes and transaction types.
// No dependencies; used by teq_cell and timed_event_queue.
`timescale 1ns / 1ps

package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS);
    localparam int TIME_W      = 48;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIRED    = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_DROPPED  = 2'd2,
        KIND_STALE    = 2'd3
    } result_kind_t;

    // Input transaction
    typedef struct packed {
        cmd_t              command;
        logic [TIME_W-1:0] due_time;
        logic              manual_flag;
        logic [7:0]        press_angle;
        logic [7:0]        rest_angle;
        logic [10:0]       hold_time;
        logic              debug_flag;
        logic [TIME_W-1:0] now_time;
    } teq_req_t;

    // Result transaction
    typedef struct packed {
        result_kind_t      result_kind;
        logic [7:0]        fire_press_angle;
        logic [7:0]        fire_rest_angle;
        logic [10:0]       fire_hold_time;
        logic              fire_debug;
        logic [TIME_W-1:0] late_by;
        logic              last_result;
    } teq_result_t;

    // Stored event payload
    typedef struct packed {
        logic        manual;
        logic        debug;
        logic [10:0] hold;
        logic [7:0]  rest;
        logic [7:0]  press;
    } teq_payload_t;

    // One queue slot as seen by its neighbours
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] due;
        teq_payload_t      payload;
    } teq_entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ADVANCE,
        CELL_PURGE,
        CELL_COMPACT
    } cell_op_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] new_due;
        teq_payload_t      new_payload;
    } teq_cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TICK,
        ST_PURGE,
        ST_COMPACT
    } teq_state_t;

endpackage

### src/timed_event_queue.sv
// Timed event queue: insert busy in ST_INSERT, result on the cycle after it.
// Tick: one fired result per cycle until none is due or MAX_RESULTS fired.
// Start/stop: a purge step, then compaction steps until no hole is left,
// as holes bubble through the cell chain. Results cannot be stalled.
// Reset empties the queue and leaves the run flag clear.
// Depends on teq_pkg, teq_cell and timed_event_queue_defines.svh.
`timescale 1ns / 1ps
`include "timed_event_queue_defines.svh"

module timed_event_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  teq_pkg::teq_req_t    request,
    output logic                 result_valid,
    output teq_pkg::teq_result_t result
);
    import teq_pkg::*;

    teq_state_t             state_reg, state_next;
    teq_req_t               item_reg;
    logic                   run_reg, run_next;
    logic [FIRE_CNT_W-1:0]  fired_cnt_reg, fired_cnt_next;
    logic                   result_valid_reg, result_valid_next;
    teq_result_t            result_reg, result_next;

    teq_cell_ctrl_t         cell_ctrl;
    teq_entry_t             entries [QUEUE_DEPTH];
    teq_entry_t             left_in [QUEUE_DEPTH];
    teq_entry_t             right_in [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt_vec;
    logic [QUEUE_DEPTH-1:0] left_gt_vec;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-2:0] hole_vec;

    logic                   accept;
    logic                   fire_now;
    logic                   more_due;
    logic                   has_holes;
    logic                   stale;
    logic                   full;

    assign accept       = start && !busy;
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_in[gi]     = '{valid: 1'b1, due: '0, payload: '0};
                assign left_gt_vec[gi] = 1'b0;
            end
            else
            begin : g_mid
                assign left_in[gi]     = entries[gi-1];
                assign left_gt_vec[gi] = gt_vec[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_in[gi] = '{valid: 1'b0, due: '0, payload: '0};
            end
            else
            begin : g_inner
                assign right_in[gi] = entries[gi+1];
                assign hole_vec[gi] = !entries[gi].valid && entries[gi+1].valid;
            end
            assign valid_vec[gi] = entries[gi].valid;

            teq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .left_entry  (left_in[gi]),
                .right_entry (right_in[gi]),
                .left_gt     (left_gt_vec[gi]),
                .gt          (gt_vec[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // Head-of-queue status
    assign fire_now  = entries[0].valid && (entries[0].due <= item_reg.now_time);
    assign more_due  = entries[1].valid && (entries[1].due <= item_reg.now_time)
                       && (fired_cnt_reg != FIRE_CNT_W'(MAX_RESULTS - 1));
    assign has_holes = |hole_vec;
    assign stale     = !item_reg.manual_flag && !run_reg;
    assign full      = valid_vec[QUEUE_DEPTH-1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.command)
                        CMD_INSERT: state_next = ST_INSERT;
                        CMD_TICK:   state_next = ST_TICK;
                        CMD_START,
                        CMD_STOP:   state_next = ST_PURGE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT:  state_next = ST_IDLE;
            ST_TICK:    state_next = (fire_now && more_due) ? ST_TICK : ST_IDLE;
            ST_PURGE:   state_next = ST_COMPACT;
            ST_COMPACT: state_next = has_holes ? ST_COMPACT : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs: cell control, results, run flag, fire count
    always_comb
    begin
        cell_ctrl.op                = CELL_HOLD;
        cell_ctrl.new_due           = item_reg.due_time;
        cell_ctrl.new_payload       = '{manual: item_reg.manual_flag,
                                        debug:  item_reg.debug_flag,
                                        hold:   item_reg.hold_time,
                                        rest:   item_reg.rest_angle,
                                        press:  item_reg.press_angle};
        result_valid_next           = 1'b0;
        result_next                 = '0;
        run_next                    = run_reg;
        fired_cnt_next              = fired_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                fired_cnt_next = '0;
            end
            ST_INSERT:
            begin
                result_valid_next       = 1'b1;
                result_next.last_result = 1'b1;
                priority if (stale)
                begin
                    result_next.result_kind = KIND_STALE;
                end
                else if (full)
                begin
                    result_next.result_kind = KIND_DROPPED;
                end
                else
                begin
                    result_next.result_kind = KIND_ACCEPTED;
                    cell_ctrl.op            = CELL_INSERT;
                end
            end
            ST_TICK:
            begin
                if (fire_now)
                begin
                    cell_ctrl.op                 = CELL_ADVANCE;
                    result_valid_next            = 1'b1;
                    result_next.result_kind      = KIND_FIRED;
                    result_next.fire_press_angle = entries[0].payload.press;
                    result_next.fire_rest_angle  = entries[0].payload.rest;
                    result_next.fire_hold_time   = entries[0].payload.hold;
                    result_next.fire_debug       = entries[0].payload.debug;
                    result_next.late_by          = item_reg.now_time - entries[0].due;
                    result_next.last_result      = !more_due;
                    fired_cnt_next               = fired_cnt_reg + 1'b1;
                end
            end
            ST_PURGE:
            begin
                cell_ctrl.op = CELL_PURGE;
                run_next     = (item_reg.command == CMD_START);
            end
            ST_COMPACT:
            begin
                cell_ctrl.op = CELL_COMPACT;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            run_reg          <= 1'b0;
            fired_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            run_reg          <= run_next;
            fired_cnt_reg    <= fired_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Transaction payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= request;
        end
        result_reg <= result_next;
    end

    // Checks
    `TEQ_ASSERT_NOW(a_idle_compact, clk, rst_n, state_reg == ST_IDLE, !has_holes,
        "queue has a gap while idle")
    `TEQ_ASSERT_NOW(a_insert_last, clk, rst_n,
        result_valid_reg && (result_reg.result_kind != KIND_FIRED),
        result_reg.last_result, "insert result not marked last")
    `TEQ_ASSERT_NEXT(a_full_no_accept, clk, rst_n,
        (state_reg == ST_INSERT) && full,
        result_reg.result_kind != KIND_ACCEPTED, "insert accepted into full queue")
    `TEQ_ASSERT_NEXT(a_result_source, clk, rst_n,
        !((state_reg == ST_INSERT) || (state_reg == ST_TICK)),
        !result_valid_reg, "result outside insert or tick")

endmodule

### src/teq_cell.sv
// One slot of the sorted event chain: holds an entry and trades it with
// its neighbours. Depends on teq_pkg.
`timescale 1ns / 1ps

module teq_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  teq_pkg::teq_cell_ctrl_t ctrl,
    input  teq_pkg::teq_entry_t     left_entry,
    input  teq_pkg::teq_entry_t     right_entry,
    input  logic                    left_gt,
    output logic                    gt,
    output teq_pkg::teq_entry_t     entry
);
    import teq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] due_reg, due_next;
    teq_payload_t      payload_reg, payload_next;

    // Empty slots sort after everything
    assign gt = !valid_reg || (due_reg > ctrl.new_due);

    assign entry.valid   = valid_reg;
    assign entry.due     = due_reg;
    assign entry.payload = payload_reg;

    // Next slot contents
    always_comb
    begin
        valid_next   = valid_reg;
        due_next     = due_reg;
        payload_next = payload_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        valid_next   = left_entry.valid;
                        due_next     = left_entry.due;
                        payload_next = left_entry.payload;
                    end
                    else
                    begin
                        valid_next   = 1'b1;
                        due_next     = ctrl.new_due;
                        payload_next = ctrl.new_payload;
                    end
                end
            end
            CELL_ADVANCE:
            begin
                valid_next   = right_entry.valid;
                due_next     = right_entry.due;
                payload_next = right_entry.payload;
            end
            CELL_PURGE:
            begin
                valid_next = valid_reg && payload_reg.manual;
            end
            CELL_COMPACT:
            begin
                // a hole swaps with a filled slot on its right
                if (!valid_reg && right_entry.valid)
                begin
                    valid_next   = 1'b1;
                    due_next     = right_entry.due;
                    payload_next = right_entry.payload;
                end
                else if (valid_reg && !left_entry.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot data
    always_ff @(posedge clk)
    begin
        due_reg     <= due_next;
        payload_reg <= payload_next;
    end

endmodule

### tb/sv/timed_event_queue_tb.sv
// Self-checking testbench for timed_event_queue: directed and random command streams.
// A scoreboard class models the sorted event store and checks every result.
// Depends on teq_pkg and the timed_event_queue RTL.
`timescale 1ns / 1ps

module timed_event_queue_tb;

    import teq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 125;

    // One stored event in the model
    typedef struct packed {
        logic [TIME_W-1:0] due;
        teq_payload_t      load;
    } slot_t;

    // Event store model plus queue of expected results
    class queue_scoreboard;
        slot_t       slots[$];
        teq_result_t pending_results[$];
        bit          running;
        int          failures;
        int          transactions;
        int          fired_cnt;
        int          accepted_cnt;
        int          dropped_cnt;
        int          stale_cnt;

        function new();
            running      = 1'b0;
            failures     = 0;
            transactions = 0;
            fired_cnt    = 0;
            accepted_cnt = 0;
            dropped_cnt  = 0;
            stale_cnt    = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Update the model for one accepted transaction and queue its results
        function void predict_request(teq_req_t r);
            teq_result_t res;
            slot_t       s;
            slot_t       kept[$];
            int          i;
            int          n;

            transactions++;
            res = '0;
            res.last_result = 1'b1;
            case (r.command)
                CMD_INSERT:
                begin
                    if (!r.manual_flag && !running)
                    begin
                        res.result_kind = KIND_STALE;
                        stale_cnt++;
                    end
                    else if (slots.size() >= QUEUE_DEPTH)
                    begin
                        res.result_kind = KIND_DROPPED;
                        dropped_cnt++;
                    end
                    else
                    begin
                        s.due          = r.due_time;
                        s.load.manual  = r.manual_flag;
                        s.load.debug   = r.debug_flag;
                        s.load.hold    = r.hold_time;
                        s.load.rest    = r.rest_angle;
                        s.load.press   = r.press_angle;
                        // equal due times stay in arrival order
                        i = slots.size();
                        while (i > 0 && slots[i-1].due > r.due_time)
                            i--;
                        slots.insert(i, s);
                        res.result_kind = KIND_ACCEPTED;
                        accepted_cnt++;
                    end
                    pending_results.push_back(res);
                end
                CMD_TICK:
                begin
                    n = 0;
                    while (n < MAX_RESULTS && slots.size() > 0 &&
                           slots[0].due <= r.now_time)
                    begin
                        s = slots.pop_front();
                        res = '0;
                        res.result_kind      = KIND_FIRED;
                        res.fire_press_angle = s.load.press;
                        res.fire_rest_angle  = s.load.rest;
                        res.fire_hold_time   = s.load.hold;
                        res.fire_debug       = s.load.debug;
                        res.late_by          = r.now_time - s.due;
                        n++;
                        res.last_result = (n == MAX_RESULTS || slots.size() == 0 ||
                                           slots[0].due > r.now_time);
                        pending_results.push_back(res);
                        fired_cnt++;
                    end
                end
                default:
                begin
                    // start/stop: set run flag, keep manual entries only
                    running = (r.command == CMD_START);
                    foreach (slots[k])
                        if (slots[k].load.manual)
                            kept.push_back(slots[k]);
                    slots = kept;
                end
            endcase
        endfunction

        function void check_field(string field, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(teq_result_t got);
            teq_result_t want;

            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: kind %0d", got.result_kind);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            check_field("result_kind", TIME_W'(want.result_kind),
                        TIME_W'(got.result_kind));
            check_field("fire_press_angle", TIME_W'(want.fire_press_angle),
                        TIME_W'(got.fire_press_angle));
            check_field("fire_rest_angle", TIME_W'(want.fire_rest_angle),
                        TIME_W'(got.fire_rest_angle));
            check_field("fire_hold_time", TIME_W'(want.fire_hold_time),
                        TIME_W'(got.fire_hold_time));
            check_field("fire_debug", TIME_W'(want.fire_debug),
                        TIME_W'(got.fire_debug));
            check_field("late_by", want.late_by, got.late_by);
            check_field("last_result", TIME_W'(want.last_result),
                        TIME_W'(got.last_result));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    teq_req_t    request;
    logic        result_valid;
    teq_result_t result;

    queue_scoreboard   sb;
    logic [TIME_W-1:0] sim_ms;
    int                stall_cycles;

    timed_event_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    // Every field random, any command
    function automatic teq_req_t noise_item();
        teq_req_t r;
        r.command     = cmd_t'($urandom_range(3));
        r.due_time    = rand48();
        r.manual_flag = 1'($urandom_range(1));
        r.press_angle = 8'($urandom_range(255));
        r.rest_angle  = 8'($urandom_range(255));
        r.hold_time   = 11'($urandom_range(2047));
        r.debug_flag  = 1'($urandom_range(1));
        r.now_time    = rand48();
        return r;
    endfunction

    function automatic teq_req_t ins(logic [TIME_W-1:0] due, logic manual,
                                     logic [7:0] press, logic [7:0] rest,
                                     logic [10:0] hold, logic debug);
        teq_req_t r;
        r             = noise_item();
        r.command     = CMD_INSERT;
        r.due_time    = due;
        r.manual_flag = manual;
        r.press_angle = press;
        r.rest_angle  = rest;
        r.hold_time   = hold;
        r.debug_flag  = debug;
        return r;
    endfunction

    function automatic teq_req_t ctl(cmd_t cmd, logic [TIME_W-1:0] now);
        teq_req_t r;
        r          = noise_item();
        r.command  = cmd;
        r.now_time = now;
        return r;
    endfunction

    // Mostly plausible traffic around a running clock, some noise
    function automatic teq_req_t random_item();
        teq_req_t r;
        int       sel;

        r = noise_item();
        if ($urandom_range(99) < 10)
            return r;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            r.command     = CMD_INSERT;
            r.due_time    = ($urandom_range(99) < 8) ? sim_ms - $urandom_range(50)
                                                    : sim_ms + $urandom_range(300);
            r.manual_flag = ($urandom_range(99) < 20);
            if ($urandom_range(99) < 90)
            begin
                r.press_angle = 8'($urandom_range(180));
                r.rest_angle  = 8'($urandom_range(180));
                r.hold_time   = 11'($urandom_range(2000, 1));
            end
        end
        else if (sel < 90)
        begin
            r.command  = CMD_TICK;
            sim_ms     = sim_ms + $urandom_range(80);
            r.now_time = sim_ms;
        end
        else if (sel < 96)
        begin
            r.command = CMD_START;
            // occasionally jump the time base so high bits move
            if ($urandom_range(99) < 30)
                sim_ms = rand48();
        end
        else
            r.command = CMD_STOP;
        return r;
    endfunction

    // Present one transaction after a random gap, return once accepted
    task automatic drive_item(teq_req_t item, int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   = 1'b1;
        request = item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off until every expected result has arrived
    task automatic wait_quiet();
        start = 1'b0;
        while (sb.outstanding() > 0)
            @(negedge clk);
    endtask

    // Monitor: check results, then feed accepted transactions to the model
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
                sb.predict_request(request);
        end
    end

    // Watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_pct[3];

        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        sim_ms       = 48'd1000;
        idle_pct     = '{0, 88, 9};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: stale insert with odd values, empty tick, manual extremes
        drive_item(ins('1, 1'b0, 8'd255, 8'd255, 11'd2047, 1'b1), 0);
        drive_item(ctl(CMD_TICK, '0), 0);
        drive_item(ins('1, 1'b1, 8'd255, 8'd255, 11'd2047, 1'b1), 0);
        drive_item(ins('0, 1'b1, 8'd0, 8'd0, 11'd0, 1'b0), 0);
        drive_item(ctl(CMD_START, '0), 0);
        // equal due times keep arrival order; exact-time fire is not late
        drive_item(ins(48'd100, 1'b0, 8'd10, 8'd20, 11'd30, 1'b1), 0);
        drive_item(ins(48'd100, 1'b0, 8'd11, 8'd21, 11'd31, 1'b0), 0);
        drive_item(ins(48'd50, 1'b0, 8'd180, 8'd0, 11'd2000, 1'b1), 0);
        drive_item(ins(48'd500, 1'b0, 8'd90, 8'd45, 11'd1, 1'b0), 0);
        drive_item(ctl(CMD_TICK, 48'd100), 0);
        // start while already running still purges the pending event
        drive_item(ctl(CMD_START, '0), 0);
        drive_item(ctl(CMD_TICK, 48'd600), 0);
        drive_item(ctl(CMD_STOP, '0), 0);
        drive_item(ctl(CMD_TICK, '1), 0);
        // fill the store, overflow it, then fire all sixteen in one tick
        drive_item(ctl(CMD_START, '0), 0);
        for (int k = 0; k < QUEUE_DEPTH; k++)
            drive_item(ins(TIME_W'($urandom_range(7)), k[0], 8'($urandom_range(180)),
                           8'($urandom_range(180)), 11'($urandom_range(2000, 1)),
                           1'($urandom_range(1))), 0);
        drive_item(ins(48'd3, 1'b1, 8'd1, 8'd2, 11'd3, 1'b1), 0);
        drive_item(ctl(CMD_TICK, 48'd7), 0);
        drive_item(ctl(CMD_STOP, '0), 0);
        wait_quiet();

        // Random phases with different sender idling, drained in between
        for (int p = 0; p < 3; p++)
        begin
            drive_item(ctl(CMD_START, '0), idle_pct[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
                drive_item(random_item(), idle_pct[p]);
            wait_quiet();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d transactions driven; results: %0d fired, %0d accepted,",
                 sb.transactions, sb.fired_cnt, sb.accepted_cnt);
        $display("%0d dropped on full store, %0d discarded while stopped",
                 sb.dropped_cnt, sb.stale_cnt);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
